// ----- hw/rtl/cle_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the console line editor.
// No dependencies.
package cle_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_LINE,
    ST_END
  } cle_state_t;

  // Echo sequence selected by the accepted byte
  typedef enum logic [2:0] {
    SEQ_ENTER,
    SEQ_CTRLC,
    SEQ_ERASE,
    SEQ_PRINT,
    SEQ_BELL
  } echo_seq_t;

  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_LINE = 2'd1,
    KIND_END  = 2'd2
  } item_kind_t;

  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_BELL  = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int LEN_W = 6;

  // Index of the final echo step of a sequence
  function automatic logic [1:0] echo_last_step(input echo_seq_t seq);
    logic [1:0] r;
    case (seq)
      SEQ_ENTER: r = 2'd1;
      SEQ_CTRLC: r = 2'd3;
      SEQ_ERASE: r = 2'd2;
      SEQ_PRINT: r = 2'd0;
      SEQ_BELL:  r = 2'd0;
      default:   r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] echo_char(input echo_seq_t seq, input logic [1:0] step,
                                           input logic [7:0] ch);
    logic [7:0] r;
    r = 8'h00;
    case (seq)
      SEQ_ENTER: r = (step == 2'd0) ? CH_CR : CH_LF;
      SEQ_CTRLC: begin
        case (step)
          2'd0:    r = CH_CARET;
          2'd1:    r = CH_C;
          2'd2:    r = CH_CR;
          default: r = CH_LF;
        endcase
      end
      SEQ_ERASE: r = (step == 2'd1) ? CH_SPACE : CH_BS;
      SEQ_PRINT: r = ch;
      SEQ_BELL:  r = CH_BELL;
      default:   r = 8'h00;
    endcase
    return r;
  endfunction

  // Sequences that are followed by the stored line and a line end
  function automatic logic seq_has_line(input echo_seq_t seq);
    return (seq == SEQ_ENTER) || (seq == SEQ_CTRLC);
  endfunction

endpackage

// ----- hw/rtl/cle_line_ram.sv -----
`timescale 1ns / 1ps
// Line store: one write port, one read port with registered read data.
// No dependencies.
module cle_line_ram #(
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/console_line_editor.sv -----
`timescale 1ns / 1ps
// Console line editor top level. Uses cle_pkg and cle_line_ram.
// An accepted byte is decoded in ST_IDLE; its results come from ST_ECHO, ST_LINE
// and ST_END and are registered, one per cycle while the output is not stalled;
// in_stall holds the input until the byte's last result is registered. The line
// index counter steps the read port one store entry per cycle unless stalled.
// Reset (rst_n, synchronous) empties the line and clears the CR flag.
module console_line_editor #(
  parameter int LINE_CAPACITY = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_kind,
  output logic [7:0]               out_data_byte,
  output logic [cle_pkg::LEN_W-1:0] out_line_length,
  output logic                     out_last
);
  import cle_pkg::*;

  localparam int CW = $clog2(LINE_CAPACITY);
  localparam logic [CW-1:0] COUNT_MAX = CW'(LINE_CAPACITY - 1);

  cle_state_t state_r, state_nxt;
  echo_seq_t  seq_r, seq_nxt;
  logic [1:0]    step_r, step_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          after_cr_r, after_cr_nxt;
  logic [7:0]    ch_r, ch_nxt;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [7:0]    out_data_r;
  logic [LEN_W-1:0] out_len_r;
  logic          out_last_r;

  logic          accept, slot_free;
  logic          emit, emit_last;
  item_kind_t    emit_kind;
  logic [7:0]    emit_data;
  logic [LEN_W-1:0] emit_len;
  logic          go_echo;
  logic          wr_en;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_data_r;
  logic [CW+LEN_W-1:0] len_ext;
  logic          step_done;
  logic          is_cr, is_lf, is_print, is_erase;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign step_done = (step_r == echo_last_step(seq_r));
  assign len_ext   = {{LEN_W{1'b0}}, count_r};

  assign is_cr    = (in_rx_byte == CH_CR);
  assign is_lf    = (in_rx_byte == CH_LF);
  assign is_erase = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
  assign is_print = (in_rx_byte >= CH_SPACE) && (in_rx_byte <= CH_TILDE);

  // Decode of the accepted byte and line bookkeeping
  always_comb begin
    go_echo      = 1'b0;
    wr_en        = 1'b0;
    seq_nxt      = seq_r;
    ch_nxt       = ch_r;
    count_nxt    = count_r;
    after_cr_nxt = after_cr_r;
    if (accept) begin
      after_cr_nxt = is_cr;
      ch_nxt       = in_rx_byte;
      if (is_lf && after_cr_r) begin
        go_echo = 1'b0;
      end else if (is_cr || is_lf) begin
        go_echo = 1'b1;
        seq_nxt = SEQ_ENTER;
      end else if (in_rx_byte == CH_CTRLC) begin
        go_echo   = 1'b1;
        seq_nxt   = SEQ_CTRLC;
        count_nxt = '0;
      end else if (is_erase) begin
        if (count_r != '0) begin
          go_echo   = 1'b1;
          seq_nxt   = SEQ_ERASE;
          count_nxt = count_r - 1'b1;
        end
      end else if (is_print) begin
        go_echo = 1'b1;
        if (count_r < COUNT_MAX) begin
          wr_en     = 1'b1;
          seq_nxt   = SEQ_PRINT;
          count_nxt = count_r + 1'b1;
        end else begin
          seq_nxt = SEQ_BELL;
        end
      end
    end else if (state_r == ST_END && slot_free) begin
      count_nxt = '0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (go_echo) begin
          state_nxt = ST_ECHO;
        end
      end
      ST_ECHO: begin
        if (slot_free && step_done) begin
          if (!seq_has_line(seq_r)) begin
            state_nxt = ST_IDLE;
          end else if (count_r != '0) begin
            state_nxt = ST_LINE;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_LINE: begin
        if (slot_free && (idx_r + 1'b1 == count_r)) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result generation and counters
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_ECHO;
    emit_data = 8'h00;
    emit_len  = '0;
    emit_last = 1'b0;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = 2'd0;
        idx_nxt  = '0;
      end
      ST_ECHO: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_data = echo_char(seq_r, step_r, ch_r);
          emit_last = step_done && !seq_has_line(seq_r);
          step_nxt  = step_r + 1'b1;
        end
      end
      ST_LINE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = KIND_LINE;
          emit_data = rd_data_r;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_END: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = KIND_END;
          emit_len  = len_ext[LEN_W-1:0];
          emit_last = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Read one entry ahead so data is ready when the slot frees
  assign rd_addr = idx_nxt;

  cle_line_ram #(
    .DEPTH(LINE_CAPACITY)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (count_r),
    .wr_data   (in_rx_byte),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      after_cr_r  <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
      idx_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      after_cr_r <= after_cr_nxt;
      step_r     <= step_nxt;
      idx_r      <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    ch_r  <= ch_nxt;
    if (emit) begin
      out_kind_r <= emit_kind;
      out_data_r <= emit_data;
      out_len_r  <= emit_len;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_data_byte   = out_data_r;
  assign out_line_length = out_len_r;
  assign out_last        = out_last_r;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for console_line_editor: directed table, then random lines/bytes.
// Depends on cle_pkg and the console_line_editor RTL.
module tb_top;
  import cle_pkg::*;

  localparam int LINE_CAP = 48;
  localparam int IDLE_LIMIT = 2000;
  localparam int TOTAL_BYTES = 160;

  typedef struct {
    item_kind_t           kind;
    logic [7:0]           data;
    logic [LEN_W-1:0]     len;
    logic                 last;
  } editor_item_t;

  // How a table row is checked: by the line predictor, or by a short typed expectation
  typedef enum {
    EXP_PREDICT,
    EXP_NONE,
    EXP_ECHO,
    EXP_BELL,
    EXP_ERASE,
    EXP_ENTER_EMPTY,
    EXP_CTRLC_EMPTY
  } row_check_t;

  typedef struct {
    logic [7:0] rx;
    int         reps;
    row_check_t check;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           in_rx_byte = 8'h00;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_kind;
  logic [7:0]           out_data_byte;
  logic [LEN_W-1:0]     out_line_length;
  logic                 out_last;

  // Predictor copy of the editor state
  logic [7:0]       line_buf [LINE_CAP];
  logic [LEN_W-1:0] line_cnt;
  logic             cr_seen;

  editor_item_t step_items[$];
  editor_item_t owed_items[$];

  logic quiet = 1'b0;
  int   fail_count = 0;
  int   bytes_sent = 0;
  int   useful_bytes = 0;
  int   items_seen = 0;
  int   lines_done = 0;
  int   longest_line = 0;
  int   idle_cycles = 0;

  stim_row_t directed_rows [31] = '{
    '{CH_DEL,   1,  EXP_NONE},
    '{CH_BS,    1,  EXP_NONE},
    '{8'h00,    1,  EXP_NONE},
    '{8'hFF,    1,  EXP_NONE},
    '{8'h80,    1,  EXP_NONE},
    '{8'h1F,    1,  EXP_NONE},
    '{CH_CTRLC, 1,  EXP_CTRLC_EMPTY},
    '{CH_CR,    1,  EXP_ENTER_EMPTY},
    '{CH_LF,    1,  EXP_NONE},
    '{CH_LF,    1,  EXP_ENTER_EMPTY},
    '{CH_SPACE, 1,  EXP_ECHO},
    '{CH_TILDE, 1,  EXP_ECHO},
    '{CH_DEL,   1,  EXP_ERASE},
    '{CH_BS,    1,  EXP_ERASE},
    '{8'h61,    1,  EXP_ECHO},
    '{8'h7A,    1,  EXP_ECHO},
    '{CH_CR,    1,  EXP_PREDICT},
    '{CH_CR,    1,  EXP_ENTER_EMPTY},
    '{8'h80,    1,  EXP_NONE},
    '{CH_LF,    1,  EXP_ENTER_EMPTY},
    '{8'h71,    1,  EXP_ECHO},
    '{CH_CTRLC, 1,  EXP_PREDICT},
    '{8'h5A,    47, EXP_ECHO},
    '{CH_TILDE, 1,  EXP_BELL},
    '{CH_SPACE, 1,  EXP_BELL},
    '{CH_DEL,   1,  EXP_ERASE},
    '{8'h21,    1,  EXP_ECHO},
    '{CH_CR,    1,  EXP_PREDICT},
    '{CH_LF,    1,  EXP_NONE},
    '{8'h41,    3,  EXP_ECHO},
    '{CH_LF,    1,  EXP_PREDICT}
  };

  console_line_editor #(.LINE_CAPACITY(LINE_CAP)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void add_item(item_kind_t kind, logic [7:0] data, logic [LEN_W-1:0] len);
    step_items.push_back(editor_item_t'{kind, data, len, 1'b0});
  endfunction

  // Dump the stored line as line bytes, then the line end, and empty the line
  function automatic void close_line();
    for (int i = 0; i < line_cnt; i++) add_item(KIND_LINE, line_buf[i], '0);
    add_item(KIND_END, 8'h00, line_cnt);
    line_cnt = '0;
  endfunction

  // Expected editor output for one received byte; updates the predictor state
  function automatic void edit_byte(logic [7:0] rx);
    logic [7:0] c;
    step_items.delete();
    if (rx == CH_LF && cr_seen) begin
      cr_seen = 1'b0;
      return;
    end
    cr_seen = (rx == CH_CR);
    c = (rx == CH_CR) ? CH_LF : rx;
    if (c == CH_LF) begin
      add_item(KIND_ECHO, CH_CR, '0);
      add_item(KIND_ECHO, CH_LF, '0);
      close_line();
    end else if (c == CH_CTRLC) begin
      line_cnt = '0;
      add_item(KIND_ECHO, CH_CARET, '0);
      add_item(KIND_ECHO, CH_C, '0);
      add_item(KIND_ECHO, CH_CR, '0);
      add_item(KIND_ECHO, CH_LF, '0);
      close_line();
    end else if (c == CH_BS || c == CH_DEL) begin
      if (line_cnt != 0) begin
        line_cnt = line_cnt - 1'b1;
        add_item(KIND_ECHO, CH_BS, '0);
        add_item(KIND_ECHO, CH_SPACE, '0);
        add_item(KIND_ECHO, CH_BS, '0);
      end
    end else if (c >= CH_SPACE && c <= CH_TILDE) begin
      if (line_cnt < LINE_CAP - 1) begin
        line_buf[line_cnt] = c;
        line_cnt = line_cnt + 1'b1;
        add_item(KIND_ECHO, c, '0);
      end else begin
        add_item(KIND_ECHO, CH_BELL, '0);
      end
    end
    if (step_items.size() != 0) step_items[step_items.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(logic [7:0] rx, row_check_t check);
    while (!quiet && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    edit_byte(rx);
    if (step_items.size() != 0) useful_bytes++;
    case (check)
      EXP_PREDICT: foreach (step_items[i]) owed_items.push_back(step_items[i]);
      EXP_ECHO:    owed_items.push_back(editor_item_t'{KIND_ECHO, rx, '0, 1'b1});
      EXP_BELL:    owed_items.push_back(editor_item_t'{KIND_ECHO, CH_BELL, '0, 1'b1});
      EXP_ERASE: begin
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_BS, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_SPACE, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_BS, '0, 1'b1});
      end
      EXP_ENTER_EMPTY: begin
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_CR, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_LF, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_END, 8'h00, '0, 1'b1});
      end
      EXP_CTRLC_EMPTY: begin
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_CARET, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_C, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_CR, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_ECHO, CH_LF, '0, 1'b0});
        owed_items.push_back(editor_item_t'{KIND_END, 8'h00, '0, 1'b1});
      end
      default: ;
    endcase
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 15);
  end

  // Output checker
  always @(posedge clk) begin
    editor_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      items_seen++;
      if (owed_items.size() == 0) begin
        fail_count++;
        $display("%0t: expected no item, got kind=%0d data=%02h len=%0d last=%0b", $time,
                 out_kind, out_data_byte, out_line_length, out_last);
      end else begin
        want = owed_items.pop_front();
        if (out_kind != want.kind || out_data_byte != want.data ||
            out_line_length != want.len || out_last != want.last) begin
          fail_count++;
          $display({"%0t: mismatch expected kind=%0d data=%02h len=%0d last=%0b,",
                    " got kind=%0d data=%02h len=%0d last=%0b"},
                   $time, want.kind, want.data, want.len, want.last,
                   out_kind, out_data_byte, out_line_length, out_last);
        end
        if (want.kind == KIND_END) begin
          lines_done++;
          if (want.len > longest_line) longest_line = want.len;
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d items still owed", $time,
                 IDLE_LIMIT, owed_items.size());
        $display("console_line_editor test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int len;
    logic [7:0] ch;
    line_cnt = '0;
    cr_seen  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < $size(directed_rows); r++)
      repeat (directed_rows[r].reps) send_byte(directed_rows[r].rx, directed_rows[r].check);

    // Hold off until the editor has flushed everything
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_items.size() != 0) @(posedge clk);

    while (bytes_sent < TOTAL_BYTES) begin
      quiet = (bytes_sent >= 100 && bytes_sent < 130);
      if ($urandom_range(3) != 0) begin
        // a typed line: mostly short, now and then long enough to overflow
        len = ($urandom_range(7) == 0) ? $urandom_range(52, 44) : $urandom_range(12, 0);
        for (int k = 0; k < len && bytes_sent < TOTAL_BYTES; k++) begin
          if ($urandom_range(9) == 0)
            ch = $urandom_range(1) ? CH_BS : CH_DEL;
          else
            ch = 8'($urandom_range(CH_TILDE, CH_SPACE));
          send_byte(ch, EXP_PREDICT);
        end
        case ($urandom_range(4))
          0: send_byte(CH_CR, EXP_PREDICT);
          1: send_byte(CH_LF, EXP_PREDICT);
          2: begin
            send_byte(CH_CR, EXP_PREDICT);
            send_byte(CH_LF, EXP_PREDICT);
          end
          3: send_byte(CH_CTRLC, EXP_PREDICT);
          default: begin
            send_byte(CH_CR, EXP_PREDICT);
            send_byte(8'($urandom_range(255)), EXP_PREDICT);
            send_byte(CH_LF, EXP_PREDICT);
          end
        endcase
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)), EXP_PREDICT);
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (owed_items.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Fed %0d bytes (%0d with a visible effect); checked %0d output items.",
             bytes_sent, useful_bytes, items_seen);
    $display("Saw %0d completed lines, longest %0d chars; %0d mismatches.",
             lines_done, longest_line, fail_count);
    if (fail_count == 0) begin
      $display("console_line_editor test passed");
    end else begin
      $display("console_line_editor test failed");
    end
    $finish;
  end

endmodule
